>>> rtl/aesp_pkg.sv
// ----------------------------------------------------------------------------
// aesp_pkg
// shared widths, register codes, reset values and the pair energy function
// ----------------------------------------------------------------------------
package aesp_pkg;

  // fixed field widths
  localparam int VN_W     = 5;
  localparam int MOORE_W  = 25;
  localparam int EN_W     = 16;
  localparam int LANE_W   = EN_W + 1;
  localparam int DELTA_W  = 21;
  localparam int PROB_W   = 16;
  localparam int EXP_W    = 17;
  localparam int TEMP_W   = 16;
  localparam int PROD_W   = (DELTA_W - 1) + TEMP_W;

  // parameter defaults
  localparam int VN_SLOTS_DEF  = 5;
  localparam int MOORE_SLOTS_DEF = 25;
  localparam int EXP_DEPTH_DEF = 1024;

  // config port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // e^-1/64 in Q0.32
  localparam logic [63:0] EXP_STEP_RATIO = 64'd4228380000;

  // register reset values
  localparam logic [EN_W-1:0]   RST_CELL_CELL = 16'd819;
  localparam logic [EN_W-1:0]   RST_LAB_LAB   = 16'd819;
  localparam logic [EN_W-1:0]   RST_LAB_CELL  = 16'd410;
  localparam logic [EN_W-1:0]   RST_CELL_BND  = 16'd819;
  localparam logic [EN_W-1:0]   RST_LAB_BND   = 16'd819;
  localparam logic [TEMP_W-1:0] RST_INV_TEMP  = 16'd2560;
  localparam logic [PROB_W-1:0] RST_STEP_FRAC = 16'd0;

  typedef enum logic [2:0] {
    REG_CELL_CELL = 3'd0,
    REG_LAB_LAB   = 3'd1,
    REG_LAB_CELL  = 3'd2,
    REG_CELL_BND  = 3'd3,
    REG_LAB_BND   = 3'd4,
    REG_INV_TEMP  = 3'd5,
    REG_STEP_FRAC = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [EN_W-1:0] cc;
    logic [EN_W-1:0] ll;
    logic [EN_W-1:0] lc;
    logic [EN_W-1:0] cb;
    logic [EN_W-1:0] lb;
  } energy_t;

  // occupancy and label of the two swapped nodes (labels already masked)
  typedef struct packed {
    logic o1;
    logic l1;
    logic o2;
    logic l2;
  } node_t;

  // one von Neumann slot as seen from one node
  typedef struct packed {
    logic pres;
    logic occ;
    logic lab;
  } slot_t;

  function automatic logic [EN_W-1:0] pair_energy(input logic a_occ, input logic a_lab,
                                                   input logic b_occ, input logic b_lab,
                                                   input energy_t e);
    logic [EN_W-1:0] r;
    if (!a_occ && !b_occ) r = '0;
    else if (!a_occ) r = b_lab ? e.lb : e.cb;
    else if (!b_occ) r = a_lab ? e.lb : e.cb;
    else if (a_lab && b_lab) r = e.ll;
    else if (a_lab || b_lab) r = e.lc;
    else r = e.cc;
    return r;
  endfunction

endpackage

>>> rtl/adhesion_energy_switch_probability_top.sv
// ----------------------------------------------------------------------------
// adhesion_energy_switch_probability_top
// differential adhesion energy change and metropolis switch probability for
// one proposed swap of two adjacent lattice nodes
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o   | node bits, von neumann and moore masks
//  out     | out_valid_o / out_ready_i | probability, energy change, flags
//  config  | psel penable pwrite pready| paddr, pwdata, prdata (7 registers)
//
//  one item per cycle sustained while the output is not stalled
//  pipeline: lanes, merge adder, 20x16 multiplier, exp rom, dt multiplier
//  each stage has a valid bit; a stage loads when it is empty or its
//  successor moves, so bubbles close up and in_ready_o only falls when all
//  five stages hold items and the output is stalled
//  reset clears the stage valids and restores register defaults, no sweep
//
module adhesion_energy_switch_probability_top #(
  parameter int VN_SLOTS        = aesp_pkg::VN_SLOTS_DEF,
  parameter int MOORE_SLOTS     = aesp_pkg::MOORE_SLOTS_DEF,
  parameter int EXP_TABLE_DEPTH = aesp_pkg::EXP_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                first_occupied_i,
  input  logic                                first_labelled_i,
  input  logic                                second_occupied_i,
  input  logic                                second_labelled_i,
  input  logic [aesp_pkg::VN_W-1:0]           first_nbr_present_i,
  input  logic [aesp_pkg::VN_W-1:0]           first_nbr_occupied_i,
  input  logic [aesp_pkg::VN_W-1:0]           first_nbr_labelled_i,
  input  logic [aesp_pkg::VN_W-1:0]           second_nbr_present_i,
  input  logic [aesp_pkg::VN_W-1:0]           second_nbr_occupied_i,
  input  logic [aesp_pkg::VN_W-1:0]           second_nbr_labelled_i,
  input  logic [aesp_pkg::MOORE_W-1:0]        first_moore_occupied_i,
  input  logic [aesp_pkg::MOORE_W-1:0]        second_moore_occupied_i,
  // result item
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [aesp_pkg::PROB_W-1:0]         switch_probability_o,
  output logic signed [aesp_pkg::DELTA_W-1:0] energy_change_o,
  output logic                                connected_o,
  output logic                                invalid_pair_o,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aesp_pkg::APB_AW-1:0]         paddr,
  input  logic [aesp_pkg::APB_DW-1:0]         pwdata,
  output logic [aesp_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import aesp_pkg::*;

  localparam int NSTG = 5;

  // ---------------------------------------------------------------- config
  energy_t           energy_q;
  logic [TEMP_W-1:0] inv_temp_q;
  logic [PROB_W-1:0] step_frac_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q.cc <= RST_CELL_CELL;
      energy_q.ll <= RST_LAB_LAB;
      energy_q.lc <= RST_LAB_CELL;
      energy_q.cb <= RST_CELL_BND;
      energy_q.lb <= RST_LAB_BND;
      inv_temp_q  <= RST_INV_TEMP;
      step_frac_q <= RST_STEP_FRAC;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CELL_CELL: energy_q.cc <= pwdata[EN_W-1:0];
        REG_LAB_LAB:   energy_q.ll <= pwdata[EN_W-1:0];
        REG_LAB_CELL:  energy_q.lc <= pwdata[EN_W-1:0];
        REG_CELL_BND:  energy_q.cb <= pwdata[EN_W-1:0];
        REG_LAB_BND:   energy_q.lb <= pwdata[EN_W-1:0];
        REG_INV_TEMP:  inv_temp_q  <= pwdata[TEMP_W-1:0];
        REG_STEP_FRAC: step_frac_q <= pwdata[PROB_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_CELL_CELL: prdata = APB_DW'(energy_q.cc);
      REG_LAB_LAB:   prdata = APB_DW'(energy_q.ll);
      REG_LAB_CELL:  prdata = APB_DW'(energy_q.lc);
      REG_CELL_BND:  prdata = APB_DW'(energy_q.cb);
      REG_LAB_BND:   prdata = APB_DW'(energy_q.lb);
      REG_INV_TEMP:  prdata = APB_DW'(inv_temp_q);
      REG_STEP_FRAC: prdata = APB_DW'(step_frac_q);
      default:       prdata = '0;
    endcase
  end

  // ------------------------------------------------------- pipeline control
  // stage 0 lanes, 1 merge, 2 multiply, 3 rom, 4 output register
  logic [NSTG-1:0] vld_q, vld_d, load;

  always_comb begin
    load[NSTG-1] = ~vld_q[NSTG-1] | out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = ~vld_q[k] | load[k+1];
    end
    vld_d[0] = load[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = load[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= vld_d;
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[NSTG-1];

  // ----------------------------------------------------- stage 0: the lanes
  node_t node;
  logic  conn_in, inv_in;
  logic  s1_conn_q, s1_inv_q;
  logic [LANE_W-1:0] lane_before [VN_SLOTS];
  logic [LANE_W-1:0] lane_after  [VN_SLOTS];

  always_comb begin
    node.o1 = first_occupied_i;
    node.l1 = first_occupied_i & first_labelled_i;
    node.o2 = second_occupied_i;
    node.l2 = second_occupied_i & second_labelled_i;
    inv_in  = ~first_occupied_i & ~second_occupied_i;
    // a lone cell must keep some moore neighbour after it moves
    if (inv_in) conn_in = 1'b0;
    else if (first_occupied_i && second_occupied_i) conn_in = 1'b1;
    else if (first_occupied_i) conn_in = |second_moore_occupied_i[MOORE_SLOTS-1:0];
    else conn_in = |first_moore_occupied_i[MOORE_SLOTS-1:0];
  end

  for (genvar s = 0; s < VN_SLOTS; s++) begin : g_lane
    slot_t slot1, slot2;
    assign slot1 = '{pres: first_nbr_present_i[s], occ: first_nbr_occupied_i[s],
                     lab: first_nbr_labelled_i[s]};
    assign slot2 = '{pres: second_nbr_present_i[s], occ: second_nbr_occupied_i[s],
                     lab: second_nbr_labelled_i[s]};
    aesp_lane u_lane (
      .clk_i         (clk_i),
      .en_i          (load[0]),
      .first_slot_i  (slot1),
      .second_slot_i (slot2),
      .node_i        (node),
      .energy_i      (energy_q),
      .before_o      (lane_before[s]),
      .after_o       (lane_after[s])
    );
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_conn_q <= conn_in;
      s1_inv_q  <= inv_in;
    end
  end

  // ------------------------------------------------------ stage 1: merge
  logic signed [DELTA_W-1:0] s2_delta;
  logic                      s2_conn_q, s2_inv_q;

  aesp_merge #(.VN_SLOTS(VN_SLOTS)) u_merge (
    .clk_i    (clk_i),
    .en_i     (load[1]),
    .before_i (lane_before),
    .after_i  (lane_after),
    .delta_o  (s2_delta)
  );

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s2_conn_q <= s1_conn_q;
      s2_inv_q  <= s1_inv_q;
    end
  end

  // ------------------------------------- stage 2: change times inv temperature
  logic                      pos_d;
  logic [PROD_W-1:0]         s3_prod_q;
  logic                      s3_pos_q, s3_conn_q, s3_inv_q;
  logic signed [DELTA_W-1:0] s3_delta_q;

  assign pos_d = ~s2_delta[DELTA_W-1] & (s2_delta != '0);

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s3_prod_q  <= PROD_W'(s2_delta[DELTA_W-2:0]) * PROD_W'(inv_temp_q);
      s3_pos_q   <= pos_d;
      s3_delta_q <= s2_delta;
      s3_conn_q  <= s2_conn_q;
      s3_inv_q   <= s2_inv_q;
    end
  end

  // ------------------------------------------------------ stage 3: exp rom
  logic [EXP_W-1:0]          s4_entry;
  logic                      s4_pos_q, s4_conn_q, s4_inv_q;
  logic signed [DELTA_W-1:0] s4_delta_q;

  aesp_exp #(.EXP_DEPTH(EXP_TABLE_DEPTH)) u_exp (
    .clk_i   (clk_i),
    .en_i    (load[3]),
    .prod_i  (s3_prod_q),
    .entry_o (s4_entry)
  );

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s4_pos_q   <= s3_pos_q;
      s4_delta_q <= s3_delta_q;
      s4_conn_q  <= s3_conn_q;
      s4_inv_q   <= s3_inv_q;
    end
  end

  // ------------------------------------- stage 4: dt scaling, output register
  logic [PROB_W+EXP_W:0]     scaled;
  logic [PROB_W-1:0]         prob_d, prob_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic                      conn_q, inv_q;

  always_comb begin
    // rounded product never exceeds dt, so the upper bits are zero
    scaled = (PROB_W+EXP_W+1)'(step_frac_q) * (PROB_W+EXP_W+1)'(s4_entry)
           + (PROB_W+EXP_W+1)'(1 << 15);
    if (s4_inv_q || !s4_conn_q) prob_d = '0;
    else if (!s4_pos_q) prob_d = step_frac_q;
    else prob_d = scaled[PROB_W+15:16];
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      prob_q  <= prob_d;
      delta_q <= s4_inv_q ? '0 : s4_delta_q;
      conn_q  <= s4_conn_q;
      inv_q   <= s4_inv_q;
    end
  end

  assign switch_probability_o = prob_q;
  assign energy_change_o      = delta_q;
  assign connected_o          = conn_q;
  assign invalid_pair_o       = inv_q;

endmodule

>>> rtl/aesp_lane.sv
// ----------------------------------------------------------------------------
// aesp_lane
// energy contributions of one von Neumann slot of both nodes, registered
// ----------------------------------------------------------------------------
module aesp_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  aesp_pkg::slot_t              first_slot_i,
  input  aesp_pkg::slot_t              second_slot_i,
  input  aesp_pkg::node_t              node_i,
  input  aesp_pkg::energy_t            energy_i,
  output logic [aesp_pkg::LANE_W-1:0]  before_o,
  output logic [aesp_pkg::LANE_W-1:0]  after_o
);
  import aesp_pkg::*;

  logic            s1_occ, s1_lab, s2_occ, s2_lab;
  logic [EN_W-1:0] b1, a1, b2, a2;
  logic [LANE_W-1:0] before_d, after_d, before_q, after_q;

  always_comb begin
    s1_occ = first_slot_i.pres & first_slot_i.occ;
    s1_lab = s1_occ & first_slot_i.lab;
    s2_occ = second_slot_i.pres & second_slot_i.occ;
    s2_lab = s2_occ & second_slot_i.lab;
    // own node before the swap, partner node after it
    b1 = first_slot_i.pres ? pair_energy(s1_occ, s1_lab, node_i.o1, node_i.l1, energy_i) : '0;
    a1 = first_slot_i.pres ? pair_energy(s1_occ, s1_lab, node_i.o2, node_i.l2, energy_i) : '0;
    b2 = second_slot_i.pres ? pair_energy(s2_occ, s2_lab, node_i.o2, node_i.l2, energy_i) : '0;
    a2 = second_slot_i.pres ? pair_energy(s2_occ, s2_lab, node_i.o1, node_i.l1, energy_i) : '0;
    before_d = LANE_W'(b1) + LANE_W'(b2);
    after_d  = LANE_W'(a1) + LANE_W'(a2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      before_q <= before_d;
      after_q  <= after_d;
    end
  end

  assign before_o = before_q;
  assign after_o  = after_q;

endmodule

>>> rtl/aesp_merge.sv
// ----------------------------------------------------------------------------
// aesp_merge
// sums the lane contributions and forms the registered energy change
// ----------------------------------------------------------------------------
module aesp_merge #(
  parameter int VN_SLOTS = aesp_pkg::VN_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [aesp_pkg::LANE_W-1:0]        before_i [VN_SLOTS],
  input  logic [aesp_pkg::LANE_W-1:0]        after_i  [VN_SLOTS],
  output logic signed [aesp_pkg::DELTA_W-1:0] delta_o
);
  import aesp_pkg::*;

  localparam int SUM_W = LANE_W + $clog2(VN_SLOTS);

  logic [SUM_W-1:0]          bsum, asum;
  logic signed [DELTA_W-1:0] delta_d, delta_q;

  always_comb begin
    bsum = '0;
    asum = '0;
    for (int s = 0; s < VN_SLOTS; s++) begin
      bsum = bsum + SUM_W'(before_i[s]);
      asum = asum + SUM_W'(after_i[s]);
    end
    delta_d = $signed(DELTA_W'(asum)) - $signed(DELTA_W'(bsum));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) delta_q <= delta_d;
  end

  assign delta_o = delta_q;

endmodule

>>> rtl/aesp_exp.sv
// ----------------------------------------------------------------------------
// aesp_exp
// rounds the scaled energy to a 1/64 step and reads the exponential rom
// ----------------------------------------------------------------------------
module aesp_exp #(
  parameter int EXP_DEPTH = aesp_pkg::EXP_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [aesp_pkg::PROD_W-1:0] prod_i,
  output logic [aesp_pkg::EXP_W-1:0]  entry_o
);
  import aesp_pkg::*;

  localparam int AW    = $clog2(EXP_DEPTH);
  localparam int IDX_W = PROD_W + 1 - 14;

  typedef logic [EXP_W-1:0] rom_t [EXP_DEPTH];

  // e^-k/64 in Q1.16, built by the same recurrence at elaboration
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] acc;
    logic [63:0] t;
    acc = 64'd1 << 32;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      t    = (acc + (64'd1 << 15)) >> 16;
      r[k] = t[EXP_W-1:0];
      acc  = (acc * EXP_STEP_RATIO + (64'd1 << 31)) >> 32;
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [PROD_W:0]    rnd;
  logic [IDX_W-1:0]   idx;
  logic [EXP_W-1:0]   entry_d, entry_q;

  always_comb begin
    rnd = {1'b0, prod_i} + (PROD_W+1)'(1 << 13);
    idx = rnd[PROD_W:14];
    // past the table the exponential is taken as zero
    if (idx < IDX_W'(EXP_DEPTH)) entry_d = ROM[idx[AW-1:0]];
    else entry_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/aesp_checker.sv
// ----------------------------------------------------------------------------
// aesp_checker
// port level checks on results, stalls and register readback
// ----------------------------------------------------------------------------
module aesp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [aesp_pkg::PROB_W-1:0]         switch_probability_o,
  input logic signed [aesp_pkg::DELTA_W-1:0] energy_change_o,
  input logic                                connected_o,
  input logic                                invalid_pair_o,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [aesp_pkg::APB_AW-1:0]         paddr,
  input logic [aesp_pkg::APB_DW-1:0]         pwdata,
  input logic [aesp_pkg::APB_DW-1:0]         prdata
);
  import aesp_pkg::*;

  // an empty pair carries no energy, no probability and no connection
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_pair_o |->
      switch_probability_o == '0 && energy_change_o == '0 && !connected_o)
    else $error("invalid pair result not cleared");

  // a disconnected move is never taken
  a_disconn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !connected_o |-> switch_probability_o == '0)
    else $error("probability nonzero without connection");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(switch_probability_o) && $stable(energy_change_o)
      && $stable(connected_o) && $stable(invalid_pair_o))
    else $error("stalled result changed");

  // a register written in one cycle reads back its low half word in the next
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite)
    && $past(paddr[APB_AW-1:2]) != REG_STEP_FRAC + 3'd1
    && paddr[APB_AW-1:2] == $past(paddr[APB_AW-1:2]) |->
      prdata == {16'b0, $past(pwdata[15:0])})
    else $error("register readback mismatch");

endmodule

bind adhesion_energy_switch_probability_top aesp_checker u_aesp_checker (.*);
